FILE: design/cht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_pkg
// Shared constants, codes and handshake structs of the chained hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

	localparam int NUM_BUCKETS = 1024;
	localparam int CHAIN_DEPTH = 16;

	localparam int KEY_W = 31;
	localparam int PAY_W = 32;
	localparam int CFG_W = 11;
	localparam int STATUS_W = 2;
	localparam int PROBE_W = 5;
	localparam int OCC_W = 11;

	localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int DEPTH_W = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
	localparam int LEN_W = $clog2(CHAIN_DEPTH + 1);
	localparam int SLOT_W = BKT_W + DEPTH_W;
	localparam int SLOTS = NUM_BUCKETS * (2 ** DEPTH_W);
	localparam int STEP_W = $clog2(KEY_W);

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic start;
		logic [KEY_W-1:0] dividend;
		logic [CFG_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic done;
		logic [CFG_W-1:0] remainder;
	} mod_rsp_t;

endpackage
`default_nettype wire

FILE: design/cht_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: design/cht_mod.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cht_mod
// Bit-serial restoring remainder unit: key modulo bucket count, one bit a cycle.
// ----------------------------------------------------------------------------
module cht_mod (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cht_pkg::mod_req_t req,
	output cht_pkg::mod_rsp_t      rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [cht_pkg::STEP_W-1:0]    step_q;
	logic [cht_pkg::KEY_W-1:0]     num_q;
	logic [cht_pkg::CFG_W-1:0]     div_q;
	logic [cht_pkg::CFG_W-1:0]     rem_q;
	logic [cht_pkg::CFG_W:0]       trial;
	logic [cht_pkg::CFG_W:0]       diff;

	assign trial = {rem_q, num_q[cht_pkg::KEY_W-1]};
	assign diff = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == cht_pkg::STEP_W'(cht_pkg::KEY_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[cht_pkg::KEY_W-2:0], 1'b0};
			if (!diff[cht_pkg::CFG_W]) begin
				rem_q <= diff[cht_pkg::CFG_W-1:0];
			end else begin
				rem_q <= trial[cht_pkg::CFG_W-1:0];
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.remainder = rem_q;

endmodule
`default_nettype wire

FILE: design/chained_hash_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chained_hash_table
// Separate chaining hash table, bucket = key modulo configured bucket count.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+---------------------------------------------
//  in       | in_valid / in_stall | command, key, payload
//  out      | out_valid/out_stall | status, found_payload, probes, occupied_buckets
//  cfg      | cfg_wr_en           | cfg_wr_data (bucket count)
//
// an item passes through the serial remainder, the chain length read and the
// result and the return to idle; a lookup adds a read and a compare per entry
// compared (up to 16)
// after reset a clearing pass zeroes the chain lengths, during which in_stall
// is high; a stalled result holds in the output register
// ----------------------------------------------------------------------------
module chained_hash_table (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic                            command,
	input  wire logic [cht_pkg::KEY_W-1:0]       key,
	input  wire logic [cht_pkg::PAY_W-1:0]       payload,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic      [cht_pkg::STATUS_W-1:0]    status,
	output logic      [cht_pkg::PAY_W-1:0]       found_payload,
	output logic      [cht_pkg::PROBE_W-1:0]     probes,
	output logic      [cht_pkg::OCC_W-1:0]       occupied_buckets,
	input  wire logic                            cfg_wr_en,
	input  wire logic [cht_pkg::CFG_W-1:0]       cfg_wr_data
);

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_HASH  = 8'b0000_0100,
		S_LEN   = 8'b0000_1000,
		S_CHK   = 8'b0001_0000,
		S_RD    = 8'b0010_0000,
		S_CMP   = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} state_t;

	state_t                          state_q;
	logic [cht_pkg::CFG_W-1:0]       bucket_count_q;
	logic [cht_pkg::CFG_W-1:0]       eff_div;
	logic [cht_pkg::BKT_W-1:0]       clr_q;
	logic                            cmd_q;
	logic [cht_pkg::KEY_W-1:0]       key_q;
	logic [cht_pkg::PAY_W-1:0]       pay_q;
	logic [cht_pkg::BKT_W-1:0]       bucket_q;
	logic [cht_pkg::LEN_W-1:0]       len_q;
	logic [cht_pkg::DEPTH_W-1:0]     idx_q;
	logic [cht_pkg::LEN_W-1:0]       next_probe;
	logic [cht_pkg::OCC_W-1:0]       occ_q;
	logic [cht_pkg::STATUS_W-1:0]    res_status_q;
	logic [cht_pkg::PAY_W-1:0]       res_pay_q;
	logic [cht_pkg::LEN_W-1:0]       res_probes_q;
	logic                            out_valid_q;
	logic [cht_pkg::STATUS_W-1:0]    status_q;
	logic [cht_pkg::PAY_W-1:0]       found_payload_q;
	logic [cht_pkg::PROBE_W-1:0]     probes_q;
	logic [cht_pkg::OCC_W-1:0]       occupied_q;

	cht_pkg::mod_req_t               mod_req;
	cht_pkg::mod_rsp_t               mod_rsp;

	logic                            len_we;
	logic [cht_pkg::BKT_W-1:0]       len_waddr;
	logic [cht_pkg::LEN_W-1:0]       len_wdata;
	logic [cht_pkg::LEN_W-1:0]       len_rdata;
	logic                            ent_we;
	logic [cht_pkg::SLOT_W-1:0]      ent_waddr;
	logic [cht_pkg::SLOT_W-1:0]      ent_raddr;
	logic [cht_pkg::KEY_W-1:0]       key_rdata;
	logic [cht_pkg::PAY_W-1:0]       pay_rdata;
	logic                            accept;
	logic                            full;

	// zero is used as one, values above the table size are clamped
	always_comb begin
		eff_div = bucket_count_q;
		if (bucket_count_q == '0) begin
			eff_div = cht_pkg::CFG_W'(1);
		end else if (32'(bucket_count_q) > 32'(cht_pkg::NUM_BUCKETS)) begin
			eff_div = cht_pkg::CFG_W'(cht_pkg::NUM_BUCKETS);
		end
	end

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign full = (len_rdata >= cht_pkg::LEN_W'(cht_pkg::CHAIN_DEPTH));
	assign next_probe = cht_pkg::LEN_W'(idx_q) + 1'b1;

	assign mod_req.start = accept;
	assign mod_req.dividend = key;
	assign mod_req.divisor = eff_div;

	cht_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	always_comb begin
		len_we = 1'b0;
		len_waddr = bucket_q;
		len_wdata = len_rdata + 1'b1;
		ent_we = 1'b0;
		ent_waddr = {bucket_q, len_rdata[cht_pkg::DEPTH_W-1:0]};
		ent_raddr = {bucket_q, idx_q};
		case (state_q)
			S_CLEAR: begin
				len_we = 1'b1;
				len_waddr = clr_q;
				len_wdata = '0;
			end
			S_CHK: begin
				if (cmd_q == cht_pkg::CMD_INSERT && !full) begin
					len_we = 1'b1;
					ent_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	cht_ram #(.WIDTH(cht_pkg::LEN_W), .DEPTH(cht_pkg::NUM_BUCKETS)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_waddr),
		.wdata (len_wdata),
		.raddr (bucket_q),
		.rdata (len_rdata)
	);

	cht_ram #(.WIDTH(cht_pkg::KEY_W), .DEPTH(cht_pkg::SLOTS)) u_key_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (key_q),
		.raddr (ent_raddr),
		.rdata (key_rdata)
	);

	cht_ram #(.WIDTH(cht_pkg::PAY_W), .DEPTH(cht_pkg::SLOTS)) u_pay_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (pay_q),
		.raddr (ent_raddr),
		.rdata (pay_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			bucket_count_q <= cht_pkg::CFG_RESET;
			clr_q <= '0;
			occ_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				bucket_count_q <= cfg_wr_data;
			end
			if (state_q == S_FIN && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == cht_pkg::BKT_W'(cht_pkg::NUM_BUCKETS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					if (mod_rsp.done) begin
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (cmd_q == cht_pkg::CMD_INSERT) begin
						if (!full && len_rdata == '0) begin
							occ_q <= occ_q + 1'b1;
						end
						state_q <= S_FIN;
					end else if (len_rdata == '0) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (key_rdata == key_q || next_probe == len_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_RD;
					end
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			key_q <= key;
			pay_q <= payload;
		end
		if (state_q == S_HASH && mod_rsp.done) begin
			bucket_q <= cht_pkg::BKT_W'(mod_rsp.remainder);
		end
		if (state_q == S_CHK) begin
			len_q <= len_rdata;
			idx_q <= '0;
			res_pay_q <= '0;
			res_probes_q <= '0;
			if (cmd_q == cht_pkg::CMD_INSERT) begin
				res_status_q <= full ? cht_pkg::ST_FULL : cht_pkg::ST_OK;
			end else begin
				res_status_q <= cht_pkg::ST_MISS;
			end
		end
		if (state_q == S_CMP) begin
			res_probes_q <= next_probe;
			idx_q <= idx_q + 1'b1;
			if (key_rdata == key_q) begin
				res_status_q <= cht_pkg::ST_OK;
				res_pay_q <= pay_rdata;
			end
		end
		if (state_q == S_FIN && (!out_valid_q || !out_stall)) begin
			status_q <= res_status_q;
			found_payload_q <= res_pay_q;
			probes_q <= cht_pkg::PROBE_W'(res_probes_q);
			occupied_q <= occ_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign found_payload = found_payload_q;
	assign probes = probes_q;
	assign occupied_buckets = occupied_q;

`ifndef SYNTHESIS
	a_done_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		mod_rsp.done |-> state_q == S_HASH)
		else $error("remainder done outside hash phase");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> in_stall)
		else $error("input taken during clearing pass");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= 32'(cht_pkg::NUM_BUCKETS))
		else $error("occupied count beyond bucket count");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(probes) <= 32'(cht_pkg::CHAIN_DEPTH))
		else $error("probe count beyond chain depth");

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == cht_pkg::ST_FULL |-> probes == '0 && found_payload == '0)
		else $error("dropped insert carries lookup data");
`endif

endmodule
`default_nettype wire
